// ===== sv/onst_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered name set table package
// Shared types, codes and name helpers for the ordered name set table.
// ----------------------------------------------------------------------------
package onst_pkg;

  // Default table depth and name length bound.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int NAME_BYTES      = 16;

  // Field widths of the transactions.
  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 6;
  localparam int LO_W    = 64;
  localparam int HI_W    = 56;
  localparam int NAME_W  = LO_W + HI_W;
  localparam int STAT_W  = 3;
  localparam int TOTAL_W = 7;

  // Operation codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD      = 3'd0,
    FUNC_REMOVE   = 3'd1,
    FUNC_CONTAINS = 3'd2,
    FUNC_GET      = 3'd3,
    FUNC_CLEAR    = 3'd4
  } func_code_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_DUP       = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_RANGE     = 3'd5
  } status_code_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_GET_WAIT
  } state_t;

  // Read address source and write address/data source.
  typedef enum logic [1:0] {
    RD_PTR,
    RD_NEXT,
    RD_IDX
  } rd_sel_t;

  typedef enum logic {
    WR_APPEND,
    WR_SHIFT
  } wr_sel_t;

  // Input transaction.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  item_index;
    logic [LO_W-1:0]   name_lo;
    logic [HI_W-1:0]   name_hi;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [TOTAL_W-1:0] entry_total;
    logic [LO_W-1:0]    out_name_lo;
    logic [HI_W-1:0]    out_name_hi;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         capture;
    logic         rd_en;
    rd_sel_t      rd_sel;
    logic         wr_en;
    wr_sel_t      wr_sel;
    logic         ptr_clr;
    logic         ptr_inc;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         cnt_clr;
    logic         result;
    status_code_t status;
    logic         ret_name;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              name_ok;
    logic              cnt_zero;
    logic              cnt_full;
    logic              match;
    logic              has_next;
    logic              has_next2;
    logic              idx_ok;
  } dp_stat_t;

  // Zero every byte from the first zero byte onward.
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              alive;
    res   = '0;
    alive = 1'b1;
    for (int i = 0; i < NAME_W / 8; i++) begin
      alive = alive & (raw[8*i +: 8] != 8'd0);
      if (alive) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return res;
  endfunction

  // A name is valid when it is not empty and shorter than NAME_BYTES.
  function automatic logic name_valid(input logic [NAME_W-1:0] raw);
    logic alive;
    logic too_long;
    alive    = 1'b1;
    too_long = 1'b0;
    for (int i = 0; i < NAME_W / 8; i++) begin
      alive = alive & (raw[8*i +: 8] != 8'd0);
      if (i == NAME_BYTES - 1) begin
        too_long = alive;
      end
    end
    return (raw[7:0] != 8'd0) && !too_long;
  endfunction

endpackage

// ===== sv/onst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module onst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/onst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ordered name set table controller
// Sequences lookups, shifts and reads and issues one result per transaction.
// ----------------------------------------------------------------------------
module onst_ctrl import onst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.func)
          FUNC_ADD, FUNC_REMOVE, FUNC_CONTAINS: begin
            if (!stat.name_ok) begin
              state_nxt = S_IDLE;
            end else if (stat.cnt_zero) begin
              state_nxt = S_MISS;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          FUNC_GET: begin
            state_nxt = stat.idx_ok ? S_GET_WAIT : S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          if (stat.func == FUNC_REMOVE && stat.has_next) begin
            state_nxt = S_SHIFT_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (stat.has_next) begin
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        state_nxt = S_IDLE;
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_nxt = stat.has_next2 ? S_SHIFT_RD : S_IDLE;
      end
      S_GET_WAIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_PTR;
    cmd.wr_sel = WR_APPEND;
    cmd.status = STAT_OK;
    case (state_r)
      S_IDLE: begin
        cmd.capture = start;
      end
      S_DISPATCH: begin
        case (stat.func)
          FUNC_ADD, FUNC_REMOVE, FUNC_CONTAINS: begin
            if (!stat.name_ok) begin
              cmd.result = 1'b1;
              cmd.status = STAT_EMPTY;
            end else begin
              cmd.ptr_clr = 1'b1;
            end
          end
          FUNC_GET: begin
            if (stat.idx_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_IDX;
            end else begin
              cmd.result = 1'b1;
              cmd.status = STAT_RANGE;
            end
          end
          FUNC_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.result  = 1'b1;
          end
          default: begin
            cmd.result = 1'b1;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          case (stat.func)
            FUNC_ADD: begin
              cmd.result = 1'b1;
              cmd.status = STAT_DUP;
            end
            FUNC_REMOVE: begin
              // Removing the last entry needs no shift.
              if (!stat.has_next) begin
                cmd.cnt_dec = 1'b1;
                cmd.result  = 1'b1;
              end
            end
            default: begin
              cmd.result = 1'b1;
            end
          endcase
        end else if (stat.has_next) begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_MISS: begin
        cmd.result = 1'b1;
        if (stat.func == FUNC_ADD) begin
          if (stat.cnt_full) begin
            cmd.status = STAT_FULL;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_APPEND;
            cmd.cnt_inc = 1'b1;
          end
        end else begin
          cmd.status = STAT_NOT_FOUND;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.ptr_inc = 1'b1;
        if (!stat.has_next2) begin
          cmd.cnt_dec = 1'b1;
          cmd.result  = 1'b1;
        end
      end
      S_GET_WAIT: begin
        cmd.result   = 1'b1;
        cmd.ret_name = 1'b1;
      end
      default: begin
        cmd.result = 1'b0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // An accepted transaction makes the controller busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("controller not busy after accepting a transaction");

  // Each result ends the transaction.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |=> !busy)
    else $error("controller still busy after issuing a result");

  // A table write never coincides with a read.
  a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !cmd.rd_en)
    else $error("table read and write issued together");
`endif

endmodule

// ===== sv/onst_dp.sv =====
// ----------------------------------------------------------------------------
// Ordered name set table datapath
// Request registers, entry count, scan pointer, name table and result register.
// ----------------------------------------------------------------------------
module onst_dp import onst_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = CW + 1;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  logic [FUNC_W-1:0] req_func_r;
  logic [IDX_W-1:0]  req_idx_r;
  logic [NAME_W-1:0] req_name_r;
  logic              req_ok_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [AW-1:0]     ptr_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;

  logic [NAME_W-1:0] raw_name;
  logic [NAME_W-1:0] rd_data;
  logic [NAME_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [PW-1:0]     ptr_x;
  logic [PW-1:0]     cnt_x;
  logic [XW-1:0]     idx_x;

  assign raw_name = {in_data.name_hi, in_data.name_lo};

  // Request capture; the name is normalized on the way in.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func_r <= in_data.func;
      req_idx_r  <= in_data.item_index;
      req_name_r <= norm_name(raw_name);
      req_ok_r   <= name_valid(raw_name);
    end
  end

  // Entry count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Scan and shift pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + AW'(1);
    end
  end

  // Address and data selection for the name table.
  assign ptr_x = PW'(ptr_r);
  assign cnt_x = PW'(cnt_r);
  assign idx_x = XW'(req_idx_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:  rd_addr = ptr_r;
      RD_NEXT: rd_addr = ptr_r + AW'(1);
      RD_IDX:  rd_addr = idx_x[AW-1:0];
      default: rd_addr = ptr_r;
    endcase
  end

  assign wr_addr = (cmd.wr_sel == WR_APPEND) ? cnt_r[AW-1:0] : ptr_r;
  assign wr_data = (cmd.wr_sel == WR_APPEND) ? req_name_r : rd_data;

  onst_ram #(
    .WIDTH (NAME_W),
    .DEPTH (MAX_ENTRIES)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status toward the controller.
  always_comb begin
    stat.func      = req_func_r;
    stat.name_ok   = req_ok_r;
    stat.cnt_zero  = (cnt_r == '0);
    stat.cnt_full  = (cnt_r == CW'(MAX_ENTRIES));
    stat.match     = (rd_data == req_name_r);
    stat.has_next  = ((ptr_x + PW'(1)) < cnt_x);
    stat.has_next2 = ((ptr_x + PW'(2)) < cnt_x);
    stat.idx_ok    = (idx_x < XW'(cnt_r));
  end

  // Result register; the count reported is the one after the operation.
  always_comb begin
    out_data_nxt.status      = cmd.status;
    out_data_nxt.entry_total = TOTAL_W'(cnt_nxt);
    out_data_nxt.out_name_lo = cmd.ret_name ? rd_data[LO_W-1:0] : '0;
    out_data_nxt.out_name_hi = cmd.ret_name ? rd_data[NAME_W-1:LO_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // The count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  // The count only moves together with a result.
  a_cnt_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> $past(cmd.result))
    else $error("entry count changed without a result");

  // An append only happens into a table that has room.
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.wr_sel == WR_APPEND) |-> (cnt_r < CW'(MAX_ENTRIES)))
    else $error("append into a full table");
`endif

endmodule

// ===== sv/ordered_name_set_table_top.sv =====
// A result for clear, unused codes, an empty name or a get out of range is issued from
// the dispatch state; a valid get reads the table and returns the name from get wait.
// Add, remove and contains scan the table entry by entry through the single read port,
// with a read state and a compare state for each entry, and a remove then shifts every
// later entry down with a read and a write. One transaction at a time; start is taken
// again in the cycle the result strobes. Sync reset empties the table.
// ----------------------------------------------------------------------------
// Ordered name set table
// Bounded insertion-ordered set of short names with add, remove, contains,
// get by index and clear.
// ----------------------------------------------------------------------------
module ordered_name_set_table_top import onst_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Controller.
  onst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath with the name table.
  onst_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
